### sv/fwm_pkg.sv
// shared types and constants for the flash window mirror
// no dependencies; used by every module of the block except fwm_ram
package fwm_pkg;

	localparam int MIRROR_BYTES = 131072;
	localparam int IDX_W = $clog2(MIRROR_BYTES);
	localparam int OUT_IDX_W = 17;
	localparam int CMP_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
	localparam int OFS_W = 32;
	localparam int EXT_W = OFS_W + 1;
	localparam int WLEN_W = 18;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [EXT_W-1:0] MIRROR_END = EXT_W'(MIRROR_BYTES);
	localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MIRROR_BYTES - 1);
	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;
	localparam logic [OFS_W-1:0] RESET_WINDOW_BASE = 32'h0010_0000;
	localparam logic [WLEN_W-1:0] RESET_WINDOW_LENGTH = 18'h2_0000;

	typedef enum logic [1:0] {
		ACT_PROGRAM = 2'd0,
		ACT_ERASE   = 2'd1,
		ACT_FLUSH   = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_BASE   = 1'b0,
		REG_WINDOW_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROG_CALC,
		S_PROG_READ,
		S_PROG_CHECK,
		S_ER_ENDS,
		S_ER_CLIP,
		S_ER_REL,
		S_ER_CHECK,
		S_SWEEP,
		S_REPORT
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [IDX_W-1:0]  addr;
		logic [BYTE_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic             mark;
		logic             prog;
		logic             erase;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic             clear;
	} track_cmd_t;

	typedef struct packed {
		logic                 dirty;
		logic [OUT_IDX_W-1:0] low;
		logic [OUT_IDX_W-1:0] high;
		logic [CNT_W-1:0]     progs;
		logic [CNT_W-1:0]     erases;
	} track_stat_t;

endpackage

### sv/fwm_ram.sv
// generic single-port ram with registered read data
// no dependencies
module fwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/fwm_track.sv
// dirty flag, dirty index range and saturating operation counters
// depends on fwm_pkg
module fwm_track (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fwm_pkg::track_cmd_t  cmd,
	output fwm_pkg::track_stat_t stat
);

	logic                                dirty_q;
	logic [fwm_pkg::IDX_W-1:0]           low_q;
	logic [fwm_pkg::OUT_IDX_W-1:0]       high_q;
	logic [fwm_pkg::CNT_W-1:0]           prog_cnt_q;
	logic [fwm_pkg::CNT_W-1:0]           erase_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q     <= 1'b0;
			low_q       <= '0;
			high_q      <= '0;
			prog_cnt_q  <= '0;
			erase_cnt_q <= '0;
		end else if (cmd.clear) begin
			dirty_q     <= 1'b0;
			low_q       <= '0;
			high_q      <= '0;
			prog_cnt_q  <= '0;
			erase_cnt_q <= '0;
		end else if (cmd.mark) begin
			dirty_q <= 1'b1;
			// nothing marked yet means the low end is still unset
			if (!dirty_q || (cmd.lo < low_q)) begin
				low_q <= cmd.lo;
			end
			if (fwm_pkg::CMP_W'(cmd.hi) > fwm_pkg::CMP_W'(high_q)) begin
				high_q <= fwm_pkg::OUT_IDX_W'(cmd.hi);
			end
			if (cmd.prog && (prog_cnt_q != '1)) begin
				prog_cnt_q <= prog_cnt_q + 32'd1;
			end
			if (cmd.erase && (erase_cnt_q != '1)) begin
				erase_cnt_q <= erase_cnt_q + 32'd1;
			end
		end
	end

	assign stat.dirty  = dirty_q;
	assign stat.low    = dirty_q ? fwm_pkg::OUT_IDX_W'(low_q) : '0;
	assign stat.high   = high_q;
	assign stat.progs  = prog_cnt_q;
	assign stat.erases = erase_cnt_q;

endmodule

### sv/fwm_ctrl.sv
// sequencer: window registers, offset arithmetic, read-modify-write of the
// mirror and the erase and clear sweeps; depends on fwm_pkg
module fwm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [fwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic [fwm_pkg::OFS_W-1:0]        flash_offset,
	input  logic [fwm_pkg::BYTE_W-1:0]       program_value,
	input  logic [fwm_pkg::OFS_W-1:0]        erase_length,
	input  logic                             out_free,
	output logic                             report,
	output fwm_pkg::mem_req_t                mem_req,
	input  logic [fwm_pkg::BYTE_W-1:0]       mem_rdata,
	output fwm_pkg::track_cmd_t              track_cmd
);

	fwm_pkg::state_t                   state_q, state_d;
	fwm_pkg::action_t                  act_q;
	logic [fwm_pkg::OFS_W-1:0]         base_q;
	logic [fwm_pkg::WLEN_W-1:0]        wlen_q;
	logic [fwm_pkg::OFS_W-1:0]         off_q;
	logic [fwm_pkg::BYTE_W-1:0]        val_q;
	logic [fwm_pkg::OFS_W-1:0]         len_q;
	logic [fwm_pkg::EXT_W-1:0]         a_q;
	logic [fwm_pkg::EXT_W-1:0]         b_q;
	logic                              miss_q;
	logic [fwm_pkg::IDX_W-1:0]         sweep_addr_q;
	logic [fwm_pkg::IDX_W-1:0]         sweep_last_q;
	logic                              sweep_rep_q;

	logic [fwm_pkg::EXT_W-1:0]         base_ext;
	logic [fwm_pkg::EXT_W-1:0]         off_ext;
	logic                              prog_hit;
	logic [fwm_pkg::EXT_W-1:0]         rel1_clip;
	logic [fwm_pkg::EXT_W-1:0]         er_last;
	logic                              er_skip;
	logic                              sweep_done;

	assign base_ext   = {1'b0, base_q};
	assign off_ext    = {1'b0, off_q};
	assign prog_hit   = !a_q[fwm_pkg::OFS_W] &&
		(a_q[fwm_pkg::OFS_W-1:0] < fwm_pkg::OFS_W'(wlen_q)) &&
		(a_q < fwm_pkg::MIRROR_END);
	assign rel1_clip  = (b_q > fwm_pkg::MIRROR_END) ? fwm_pkg::MIRROR_END : b_q;
	assign er_last    = rel1_clip - 33'd1;
	assign er_skip    = miss_q || (a_q >= fwm_pkg::MIRROR_END) || (rel1_clip <= a_q);
	assign sweep_done = (sweep_addr_q == sweep_last_q);

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= fwm_pkg::RESET_WINDOW_BASE;
			wlen_q <= fwm_pkg::RESET_WINDOW_LENGTH;
		end else if (cfg_wr_en) begin
			unique case (fwm_pkg::cfg_reg_t'(cfg_index))
				fwm_pkg::REG_WINDOW_BASE: begin
					base_q <= cfg_data;
				end
				fwm_pkg::REG_WINDOW_LENGTH: begin
					wlen_q <= cfg_data[fwm_pkg::WLEN_W-1:0];
				end
			endcase
		end
	end

	// state register; reset starts the clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwm_pkg::S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_last_q <= fwm_pkg::LAST_INDEX;
			sweep_rep_q  <= 1'b0;
		end else if (state_q == fwm_pkg::S_ER_CHECK) begin
			sweep_addr_q <= a_q[fwm_pkg::IDX_W-1:0];
			sweep_last_q <= er_last[fwm_pkg::IDX_W-1:0];
			sweep_rep_q  <= 1'b1;
		end else if ((state_q == fwm_pkg::S_SWEEP) && !sweep_done) begin
			sweep_addr_q <= sweep_addr_q + fwm_pkg::IDX_W'(1);
		end
	end

	// item capture and offset arithmetic
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= fwm_pkg::action_t'(action);
			off_q <= flash_offset;
			val_q <= program_value;
			len_q <= erase_length;
		end
		case (state_q)
			fwm_pkg::S_PROG_CALC: begin
				a_q <= off_ext - base_ext;
			end
			fwm_pkg::S_ER_ENDS: begin
				a_q <= off_ext + {1'b0, len_q};
				b_q <= base_ext + fwm_pkg::EXT_W'(wlen_q);
			end
			fwm_pkg::S_ER_CLIP: begin
				a_q    <= (off_ext < base_ext) ? base_ext : off_ext;
				b_q    <= (a_q > b_q) ? b_q : a_q;
				miss_q <= (a_q <= base_ext) || (off_ext >= b_q);
			end
			fwm_pkg::S_ER_REL: begin
				a_q <= a_q - base_ext;
				b_q <= b_q - base_ext;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		report    = 1'b0;
		mem_req   = '0;
		track_cmd = '0;
		unique case (state_q)
			fwm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (fwm_pkg::action_t'(action))
						fwm_pkg::ACT_PROGRAM: state_d = fwm_pkg::S_PROG_CALC;
						fwm_pkg::ACT_ERASE:   state_d = fwm_pkg::S_ER_ENDS;
						default:              state_d = fwm_pkg::S_REPORT;
					endcase
				end
			end
			fwm_pkg::S_PROG_CALC: begin
				state_d = fwm_pkg::S_PROG_READ;
			end
			fwm_pkg::S_PROG_READ: begin
				if (prog_hit) begin
					mem_req.re   = 1'b1;
					mem_req.addr = a_q[fwm_pkg::IDX_W-1:0];
					state_d      = fwm_pkg::S_PROG_CHECK;
				end else begin
					state_d = fwm_pkg::S_REPORT;
				end
			end
			fwm_pkg::S_PROG_CHECK: begin
				if (mem_rdata != val_q) begin
					mem_req.we      = 1'b1;
					mem_req.addr    = a_q[fwm_pkg::IDX_W-1:0];
					mem_req.wdata   = val_q;
					track_cmd.mark  = 1'b1;
					track_cmd.prog  = 1'b1;
					track_cmd.lo    = a_q[fwm_pkg::IDX_W-1:0];
					track_cmd.hi    = a_q[fwm_pkg::IDX_W-1:0];
				end
				state_d = fwm_pkg::S_REPORT;
			end
			fwm_pkg::S_ER_ENDS: begin
				state_d = fwm_pkg::S_ER_CLIP;
			end
			fwm_pkg::S_ER_CLIP: begin
				state_d = fwm_pkg::S_ER_REL;
			end
			fwm_pkg::S_ER_REL: begin
				state_d = fwm_pkg::S_ER_CHECK;
			end
			fwm_pkg::S_ER_CHECK: begin
				if (er_skip) begin
					state_d = fwm_pkg::S_REPORT;
				end else begin
					track_cmd.mark  = 1'b1;
					track_cmd.erase = 1'b1;
					track_cmd.lo    = a_q[fwm_pkg::IDX_W-1:0];
					track_cmd.hi    = er_last[fwm_pkg::IDX_W-1:0];
					state_d         = fwm_pkg::S_SWEEP;
				end
			end
			fwm_pkg::S_SWEEP: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = sweep_addr_q;
				mem_req.wdata = fwm_pkg::ERASED_BYTE;
				if (sweep_done) begin
					state_d = sweep_rep_q ? fwm_pkg::S_REPORT : fwm_pkg::S_IDLE;
				end
			end
			fwm_pkg::S_REPORT: begin
				if (out_free) begin
					report          = 1'b1;
					track_cmd.clear = (act_q == fwm_pkg::ACT_FLUSH);
					state_d         = fwm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fwm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### sv/flash_window_mirror_top.sv
// flash window mirror: byte mirror of one window of a larger flash with
// dirty tracking; depends on fwm_pkg, fwm_ram, fwm_ctrl, fwm_track
//
// input channel (in_valid/in_ready) carries one item per transfer: action
// program, erase or flush, with flash_offset, program_value, erase_length.
// every item gives exactly one result on the output channel
// (out_valid/out_ready): dirty flag, dirty index range and the counters.
// cfg_wr_en writes window_base (index 0) or window_length (index 1) from
// cfg_data; write only while the block is idle.
// one item is worked at a time through a single-port mirror ram:
//   program: offset calc, read, write if changed, result; a miss skips both
//   flush or unused action: straight to the result
//   erase: ends, clip, relative, check, then one mirror byte cleared a cycle
// in_ready rises as the result is loaded, so a new item is taken only after
// the previous one has given its result.
// after reset the mirror is swept to 0xFF one byte a cycle, all 131072 bytes,
// with in_ready low; window registers take their reset values at once.
// a result waits in the output register while out_ready is low; the next
// item is accepted meanwhile and holds its own result until the slot frees.
module flash_window_mirror_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [fwm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fwm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [fwm_pkg::OFS_W-1:0]            flash_offset,
	input  logic [fwm_pkg::BYTE_W-1:0]           program_value,
	input  logic [fwm_pkg::OFS_W-1:0]            erase_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 is_dirty,
	output logic [fwm_pkg::OUT_IDX_W-1:0]        dirty_low,
	output logic [fwm_pkg::OUT_IDX_W-1:0]        dirty_high,
	output logic [fwm_pkg::CNT_W-1:0]            program_count,
	output logic [fwm_pkg::CNT_W-1:0]            erase_count
);

	fwm_pkg::mem_req_t              mem_req;
	fwm_pkg::track_cmd_t            track_cmd;
	fwm_pkg::track_stat_t           stat;
	logic [fwm_pkg::BYTE_W-1:0]     mem_rdata;
	logic                           report;
	logic                           out_free;
	logic                           out_valid_q;
	fwm_pkg::track_stat_t           res_q;

	assign out_free = !out_valid_q || out_ready;

	fwm_ram #(
		.WIDTH(fwm_pkg::BYTE_W),
		.DEPTH(fwm_pkg::MIRROR_BYTES)
	) u_mirror (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	fwm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.flash_offset  (flash_offset),
		.program_value (program_value),
		.erase_length  (erase_length),
		.out_free      (out_free),
		.report        (report),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata),
		.track_cmd     (track_cmd)
	);

	fwm_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (track_cmd),
		.stat   (stat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			res_q <= stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_dirty      = res_q.dirty;
	assign dirty_low     = res_q.low;
	assign dirty_high    = res_q.high;
	assign program_count = res_q.progs;
	assign erase_count   = res_q.erases;

endmodule

### bench/tb_top.sv
// self-checking bench for flash_window_mirror_top: a clocked driver and monitor
// with random idling, checked against a shadow mirror kept in the bench
// depends on fwm_pkg and the flash_window_mirror_top rtl
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [31:0] NO_LOW_MARK = 32'hFFFF_FFFF;
	localparam int STALL_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]                 act;
		logic [fwm_pkg::OFS_W-1:0]  offset;
		logic [fwm_pkg::BYTE_W-1:0] value;
		logic [fwm_pkg::OFS_W-1:0]  elen;
	} flash_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [fwm_pkg::CFG_IDX_W-1:0] cfg_index = fwm_pkg::REG_WINDOW_BASE;
	logic [fwm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = fwm_pkg::ACT_PROGRAM;
	logic [fwm_pkg::OFS_W-1:0] flash_offset = '0;
	logic [fwm_pkg::BYTE_W-1:0] program_value = '0;
	logic [fwm_pkg::OFS_W-1:0] erase_length = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic is_dirty;
	logic [fwm_pkg::OUT_IDX_W-1:0] dirty_low;
	logic [fwm_pkg::OUT_IDX_W-1:0] dirty_high;
	logic [fwm_pkg::CNT_W-1:0] program_count;
	logic [fwm_pkg::CNT_W-1:0] erase_count;

	flash_window_mirror_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.flash_offset(flash_offset),
		.program_value(program_value),
		.erase_length(erase_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_dirty(is_dirty),
		.dirty_low(dirty_low),
		.dirty_high(dirty_high),
		.program_count(program_count),
		.erase_count(erase_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow copy of the mirror and its tracking
	logic [fwm_pkg::BYTE_W-1:0] shadow_mem [fwm_pkg::MIRROR_BYTES];
	logic [fwm_pkg::OFS_W-1:0] sh_base;
	logic [fwm_pkg::WLEN_W-1:0] sh_len;
	logic sh_dirty;
	logic [31:0] sh_low;
	logic [fwm_pkg::OUT_IDX_W-1:0] sh_high;
	logic [fwm_pkg::CNT_W-1:0] sh_progs;
	logic [fwm_pkg::CNT_W-1:0] sh_erases;

	flash_op_t queued_ops [$];
	fwm_pkg::track_stat_t predicted_stats [$];
	fwm_pkg::track_stat_t pred_stat;
	fwm_pkg::track_stat_t want_stat;

	logic [fwm_pkg::OFS_W-1:0] last_off = '0;
	logic [fwm_pkg::BYTE_W-1:0] last_val = '0;
	bit quiet = 1'b0;
	int in_gap = 0;
	int out_gap = 0;
	int stall_cycles = 0;
	int errors = 0;
	int ops_accepted = 0;
	int stats_checked = 0;
	int settings_run = 1;

	task automatic clear_marks();
		sh_dirty = 1'b0;
		sh_low = NO_LOW_MARK;
		sh_high = '0;
		sh_progs = '0;
		sh_erases = '0;
	endtask

	task automatic note_change(input logic [31:0] lo, input logic [31:0] hi);
		sh_dirty = 1'b1;
		if (lo < sh_low)
			sh_low = lo;
		if (hi > 32'(sh_high))
			sh_high = hi[fwm_pkg::OUT_IDX_W-1:0];
	endtask

	task automatic apply_op(input flash_op_t op, output fwm_pkg::track_stat_t st);
		logic [31:0] rel;
		logic [32:0] e_start, e_end, w_start, w_end, o_start, o_end, r0, r1;
		int i;
		if (op.act == fwm_pkg::ACT_PROGRAM) begin
			if (op.offset >= sh_base) begin
				rel = op.offset - sh_base;
				if (rel < 32'(sh_len) && rel < 32'(fwm_pkg::MIRROR_BYTES)) begin
					if (shadow_mem[rel[fwm_pkg::IDX_W-1:0]] != op.value) begin
						shadow_mem[rel[fwm_pkg::IDX_W-1:0]] = op.value;
						if (sh_progs != '1)
							sh_progs = sh_progs + 32'd1;
						note_change(rel, rel);
					end
				end
			end
		end else if (op.act == fwm_pkg::ACT_ERASE) begin
			e_start = {1'b0, op.offset};
			e_end = e_start + {1'b0, op.elen};
			w_start = {1'b0, sh_base};
			w_end = w_start + 33'(sh_len);
			if (e_end > w_start && e_start < w_end) begin
				o_start = (e_start < w_start) ? w_start : e_start;
				o_end = (e_end > w_end) ? w_end : e_end;
				r0 = o_start - w_start;
				r1 = o_end - w_start;
				if (r0 < 33'(fwm_pkg::MIRROR_BYTES)) begin
					if (r1 > 33'(fwm_pkg::MIRROR_BYTES))
						r1 = 33'(fwm_pkg::MIRROR_BYTES);
					if (r1 > r0) begin
						for (i = int'(r0); i < int'(r1); i++)
							shadow_mem[i[fwm_pkg::IDX_W-1:0]] = fwm_pkg::ERASED_BYTE;
						if (sh_erases != '1)
							sh_erases = sh_erases + 32'd1;
						note_change(r0[31:0], 32'(r1 - 33'd1));
					end
				end
			end
		end
		st.dirty = sh_dirty;
		st.low = (sh_low == NO_LOW_MARK) ? '0 : sh_low[fwm_pkg::OUT_IDX_W-1:0];
		st.high = sh_high;
		st.progs = sh_progs;
		st.erases = sh_erases;
		if (op.act == fwm_pkg::ACT_FLUSH && sh_dirty)
			clear_marks();
	endtask

	task automatic push_op(input logic [1:0] act, input logic [31:0] off,
			input logic [7:0] val, input logic [31:0] len);
		flash_op_t op;
		op.act = act;
		op.offset = off;
		op.value = val;
		op.elen = len;
		queued_ops.push_back(op);
	endtask

	// offset relative to the window base, biased toward both window edges
	function automatic int near_rel(input int reach);
		int r;
		case ($urandom_range(0, 2))
			0: r = $urandom_range(0, 71) - 8;
			1: r = reach - 64 + $urandom_range(0, 71);
			default: r = $urandom_range(0, reach);
		endcase
		return r;
	endfunction

	task automatic push_random_op();
		flash_op_t op;
		int unsigned pick;
		int reach;
		bit wide;
		reach = (sh_len > fwm_pkg::MIRROR_BYTES) ? fwm_pkg::MIRROR_BYTES + 16 : int'(sh_len);
		wide = reach > 4096;
		op.offset = $urandom;
		op.value = 8'($urandom);
		op.elen = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			op.act = ACT_UNUSED;
		end else if (pick < 12) begin
			op.act = fwm_pkg::ACT_FLUSH;
		end else if (pick < 60) begin
			op.act = fwm_pkg::ACT_PROGRAM;
			case ($urandom_range(0, 9))
				0: ;
				1: begin
					op.offset = last_off;
					op.value = last_val;
				end
				default: op.offset = sh_base + 32'(near_rel(reach));
			endcase
			if ($urandom_range(0, 7) == 0)
				op.value = fwm_pkg::ERASED_BYTE;
			last_off = op.offset;
			last_val = op.value;
		end else begin
			op.act = fwm_pkg::ACT_ERASE;
			if ($urandom_range(0, 9) != 0)
				op.offset = sh_base + 32'(near_rel(reach));
			// wide windows keep erases short, the clear sweeps one byte per cycle
			case ($urandom_range(0, 3))
				0: if (wide) op.elen = $urandom_range(0, 64);
				1: op.elen = $urandom_range(0, wide ? 64 : reach + 16);
				2: op.elen = $urandom_range(0, 3);
				default: begin
					op.offset = sh_base - $urandom_range(0, 32);
					op.elen = $urandom_range(0, wide ? 96 : reach + 64);
				end
			endcase
		end
		queued_ops.push_back(op);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (queued_ops.size() != 0 || in_valid || predicted_stats.size() != 0);
	endtask

	task automatic write_window(input logic [31:0] base,
			input logic [fwm_pkg::WLEN_W-1:0] len);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= fwm_pkg::REG_WINDOW_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= fwm_pkg::REG_WINDOW_LENGTH;
		cfg_data <= {14'($urandom), len};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sh_base = base;
		sh_len = len;
		settings_run++;
		@(negedge clk);
	endtask

	task automatic run_setting(input logic [31:0] base,
			input logic [fwm_pkg::WLEN_W-1:0] len, input int count);
		wait_drained();
		write_window(base, len);
		repeat (count) push_random_op();
	endtask

	task automatic cmp_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch on %s: expected %h, actual %h", $time, fname, want, got);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= fwm_pkg::ACT_PROGRAM;
			flash_offset <= '0;
			program_value <= '0;
			erase_length <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_op({action, flash_offset, program_value, erase_length}, pred_stat);
				predicted_stats.push_back(pred_stat);
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (queued_ops.size() != 0) begin
					{action, flash_offset, program_value, erase_length} <= queued_ops.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0)
						in_gap <= $urandom_range(1, 4);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_stats.size() == 0) begin
					$display("%0t unexpected transfer: expected none, actual %b %h %h %h %h",
						$time, is_dirty, dirty_low, dirty_high, program_count, erase_count);
					errors++;
				end else begin
					want_stat = predicted_stats.pop_front();
					cmp_field("is_dirty", 32'(want_stat.dirty), 32'(is_dirty));
					cmp_field("dirty_low", 32'(want_stat.low), 32'(dirty_low));
					cmp_field("dirty_high", 32'(want_stat.high), 32'(dirty_high));
					cmp_field("program_count", want_stat.progs, program_count);
					cmp_field("erase_count", want_stat.erases, erase_count);
					stats_checked++;
				end
			end
			if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		foreach (shadow_mem[i])
			shadow_mem[i] = fwm_pkg::ERASED_BYTE;
		sh_base = fwm_pkg::RESET_WINDOW_BASE;
		sh_len = fwm_pkg::RESET_WINDOW_LENGTH;
		clear_marks();

		// reset window: edges, no-change programs, partial and full erases
		push_op(fwm_pkg::ACT_PROGRAM, sh_base, 8'h00, 32'h0);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base, 8'h00, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base + 32'h1_FFFF, 8'hA5, 32'h0);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base + 32'h2_0000, 8'h12, 32'h0);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base - 32'd1, 8'h34, 32'h0);
		push_op(fwm_pkg::ACT_PROGRAM, 32'hFFFF_FFFF, 8'h00, 32'h0);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base + 32'd5, fwm_pkg::ERASED_BYTE, 32'h0);
		push_op(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_FLUSH, 32'h0, 8'h00, 32'h0);
		push_op(fwm_pkg::ACT_FLUSH, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_ERASE, sh_base, 8'h00, 32'h0);
		push_op(fwm_pkg::ACT_ERASE, sh_base - 32'd16, 8'h00, 32'd32);
		push_op(fwm_pkg::ACT_ERASE, sh_base + 32'h1_FFF0, 8'h00, 32'h100);
		push_op(fwm_pkg::ACT_ERASE, 32'h0, 8'h00, sh_base);
		push_op(fwm_pkg::ACT_ERASE, sh_base + 32'h2_0000, 8'h00, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_ERASE, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_PROGRAM, sh_base + 32'h100, 8'h55, 32'h0);
		push_op(fwm_pkg::ACT_ERASE, 32'h0, 8'h00, 32'hFFFF_FFFF);
		push_op(fwm_pkg::ACT_FLUSH, 32'h0, 8'h00, 32'h0);
		repeat (380) push_random_op();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		run_setting(32'h0000_0000, 18'd16, 250);
		run_setting(32'h0000_1000, 18'h3_FFFF, 150);
		run_setting(32'hFFFF_FFFF, 18'd0, 100);
		run_setting($urandom, 18'($urandom_range(16, 600)), 250);
		run_setting(32'hFFFF_FFFF, 18'd1, 100);
		run_setting(32'hFFFF_0000, 18'h2_0000, 200);
		wait_drained();
		quiet = 1'b1;
		run_setting($urandom, 18'($urandom_range(16, 600)), 250);

		wait_drained();
		repeat (64) @(posedge clk);
		$display("ran %0d program, erase and flush operations over %0d window settings",
			ops_accepted, settings_run);
		$display("compared %0d status reports, %0d field mismatches", stats_checked, errors);
		if (errors == 0 && predicted_stats.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
